### src/pcfd_pkg.sv
// Shared constants, register codes and saturation helpers for the PID controller core.
package pcfd_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int COEF_W           = 32;
   localparam int CSR_ADDR_W       = 5;
   localparam int CSR_DATA_W       = 32;
   // Saturated product: magnitude capped at 2^61, so 63 signed bits hold it.
   localparam int SAT_W            = 63;
   // Working width for sums ahead of the 32-bit saturation.
   localparam int WIDE_W           = 66;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_DERIV_POLE = 3'd3,
      CSR_OUT_LOW    = 3'd4,
      CSR_OUT_HIGH   = 3'd5,
      CSR_INTEG_LOW  = 3'd6,
      CSR_INTEG_HIGH = 3'd7
   } csr_index_type;

   localparam logic signed [COEF_W-1:0] Q_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] Q_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   function automatic logic signed [COEF_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [COEF_W-1:0] r;
      if (x > WIDE_W'(Q_MAX)) begin
         r = Q_MAX;
      end else if (x < WIDE_W'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = x[COEF_W-1:0];
      end
      return r;
   endfunction

   // Low limit first, then high limit, so crossed limits resolve to the high one.
   function automatic logic signed [COEF_W-1:0] clamp32(input logic signed [COEF_W-1:0] x,
                                                       input logic signed [COEF_W-1:0] lo,
                                                       input logic signed [COEF_W-1:0] hi);
      logic signed [COEF_W-1:0] r;
      r = x;
      if (r < lo) begin
         r = lo;
      end
      if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

### src/pcfd_req_if.sv
// Request and response channel interfaces of the PID controller core.
interface pcfd_req_if #(
   parameter int SAMPLE_WIDTH = pcfd_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] target;
   logic signed [SAMPLE_WIDTH-1:0] sensed;

   modport source (output valid, output target, output sensed, input ready);
   modport sink   (input valid, input target, input sensed, output ready);
endinterface

interface pcfd_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [pcfd_pkg::COEF_W-1:0]      drive;
   logic signed [pcfd_pkg::COEF_W-1:0]      p_part;
   logic signed [pcfd_pkg::COEF_W-1:0]      i_part;
   logic signed [pcfd_pkg::COEF_W-1:0]      d_part;

   modport source (output valid, output drive, output p_part, output i_part,
                   output d_part, input ready);
   modport sink   (input valid, input drive, input p_part, input i_part,
                   input d_part, output ready);
endinterface

### src/pid_controller_filtered_derivative_core.sv
// Top level of the discrete PID controller with trapezoidal integrator and filtered derivative.
//
// One item (target, sensed) in, one item (drive, p_part, i_part, d_part) out. Items are
// taken at one per clock sustained while rsp ready keeps up: an item is captured in the
// input register, then all four products, the integrator and derivative updates and the
// output clamp are evaluated in one pass and loaded into the result register when it is
// free or being drained, which raises rsp valid. The sustained rate is set by the
// derivative recursion (deriv_pole * previous d, round, subtract, saturate), which must
// close in that single pass. The result register holds a finished item while the input
// register takes the next one. Coefficients are to be written through the APB port only
// while no item is in flight, by the user; the core itself does not enforce this.
module pid_controller_filtered_derivative_core #(
   parameter int SAMPLE_WIDTH = pcfd_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = pcfd_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pcfd_req_if.sink                              req_ch,
   pcfd_rsp_if.source                            rsp_ch,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pcfd_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [pcfd_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [pcfd_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int CW    = pcfd_pkg::COEF_W;
   localparam int SW    = SAMPLE_WIDTH;
   localparam int SATW  = pcfd_pkg::SAT_W;
   localparam int WW    = pcfd_pkg::WIDE_W;
   // Wide enough for any raw product and for the 2^61 limit.
   localparam int EXT_W = (CW + SW + 2 > 64) ? CW + SW + 2 : 64;
   localparam logic signed [EXT_W-1:0] PLIM_POS = EXT_W'(64'sh2000_0000_0000_0000);
   localparam logic signed [EXT_W-1:0] PLIM_NEG = -PLIM_POS;
   // Half an LSB of the Q format for round-half-up on the pole product.
   localparam logic signed [SATW:0] POLE_HALF = (SATW+1)'(64'sd1 << (FRAC_BITS - 1));

   // ---------------------------------------------------------------- config registers
   logic signed [CW-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff, deriv_pole_ff;
   logic signed [CW-1:0] out_low_ff, out_high_ff, integ_low_ff, integ_high_ff;

   logic                    csr_wr;
   pcfd_pkg::csr_index_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   // Byte address 4*i; the two low address bits are not decoded.
   assign csr_idx = pcfd_pkg::csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         deriv_pole_ff <= '0;
         out_low_ff    <= pcfd_pkg::Q_MIN;
         out_high_ff   <= pcfd_pkg::Q_MAX;
         integ_low_ff  <= '0;
         integ_high_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            pcfd_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= pwdata;
            pcfd_pkg::CSR_INTEG_GAIN: integ_gain_ff <= pwdata;
            pcfd_pkg::CSR_DERIV_GAIN: deriv_gain_ff <= pwdata;
            pcfd_pkg::CSR_DERIV_POLE: deriv_pole_ff <= pwdata;
            pcfd_pkg::CSR_OUT_LOW:    out_low_ff    <= pwdata;
            pcfd_pkg::CSR_OUT_HIGH:   out_high_ff   <= pwdata;
            pcfd_pkg::CSR_INTEG_LOW:  integ_low_ff  <= pwdata;
            pcfd_pkg::CSR_INTEG_HIGH: integ_high_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         pcfd_pkg::CSR_PROP_GAIN:  prdata = prop_gain_ff;
         pcfd_pkg::CSR_INTEG_GAIN: prdata = integ_gain_ff;
         pcfd_pkg::CSR_DERIV_GAIN: prdata = deriv_gain_ff;
         pcfd_pkg::CSR_DERIV_POLE: prdata = deriv_pole_ff;
         pcfd_pkg::CSR_OUT_LOW:    prdata = out_low_ff;
         pcfd_pkg::CSR_OUT_HIGH:   prdata = out_high_ff;
         pcfd_pkg::CSR_INTEG_LOW:  prdata = integ_low_ff;
         pcfd_pkg::CSR_INTEG_HIGH: prdata = integ_high_ff;
         default:                  prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   logic                 s1_valid_ff;
   logic signed [SW-1:0] s1_target_ff, s1_sensed_ff;
   logic                 out_valid_ff;
   logic                 advance;

   // The input register moves forward when the result register is free or being drained.
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_target_ff <= req_ch.target;
         s1_sensed_ff <= req_ch.sensed;
      end
   end

   // ---------------------------------------------------------------- controller state
   logic signed [CW-1:0] integ_acc_ff, deriv_acc_ff;
   logic signed [SW:0]   last_error_ff;
   logic signed [SW-1:0] last_sensed_ff;

   // ---------------------------------------------------------------- datapath
   function automatic logic signed [SATW-1:0] sat_prod(input logic signed [EXT_W-1:0] x);
      logic signed [SATW-1:0] r;
      if (x > PLIM_POS) begin
         r = PLIM_POS[SATW-1:0];
      end else if (x < PLIM_NEG) begin
         r = PLIM_NEG[SATW-1:0];
      end else begin
         r = x[SATW-1:0];
      end
      return r;
   endfunction

   logic signed [SW:0]      err, dmeas;
   logic signed [SW+1:0]    esum;
   logic signed [CW+SW:0]   prod_p_raw, prod_d_raw;
   logic signed [CW+SW+1:0] prod_i_raw;
   logic signed [2*CW-1:0]  prod_pole_raw;
   logic signed [SATW-1:0]  prod_p, prod_i, prod_d, prod_pole;
   logic signed [SATW:0]    pole_sum, pole_term;
   logic signed [CW-1:0]    p_in, i_sat, i_in, d_in, drive_in;
   logic                    integ_clamp_on;

   always_comb begin
      err   = (SW+1)'(s1_target_ff) - (SW+1)'(s1_sensed_ff);
      esum  = (SW+2)'(err) + (SW+2)'(last_error_ff);
      dmeas = (SW+1)'(s1_sensed_ff) - (SW+1)'(last_sensed_ff);

      prod_p_raw    = prop_gain_ff * err;
      prod_i_raw    = integ_gain_ff * esum;
      prod_d_raw    = deriv_gain_ff * dmeas;
      prod_pole_raw = deriv_pole_ff * deriv_acc_ff;

      prod_p    = sat_prod(EXT_W'(prod_p_raw));
      prod_i    = sat_prod(EXT_W'(prod_i_raw));
      prod_d    = sat_prod(EXT_W'(prod_d_raw));
      prod_pole = sat_prod(EXT_W'(prod_pole_raw));

      p_in = pcfd_pkg::sat32(WW'(prod_p));

      // Integrator clamp is bypassed while both limits are zero.
      integ_clamp_on = (integ_low_ff != '0) || (integ_high_ff != '0);
      i_sat = pcfd_pkg::sat32(WW'(integ_acc_ff) + WW'(prod_i));
      i_in  = integ_clamp_on ? pcfd_pkg::clamp32(i_sat, integ_low_ff, integ_high_ff)
                             : i_sat;

      // Arithmetic shift floors, so half-LSB add gives round half toward +inf.
      pole_sum  = (SATW+1)'(prod_pole) + POLE_HALF;
      pole_term = pole_sum >>> FRAC_BITS;
      d_in      = pcfd_pkg::sat32(WW'(pole_term) - WW'(prod_d));

      drive_in = pcfd_pkg::clamp32(pcfd_pkg::sat32(WW'(p_in) + WW'(i_in) + WW'(d_in)),
                                   out_low_ff, out_high_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_acc_ff   <= '0;
         deriv_acc_ff   <= '0;
         last_error_ff  <= '0;
         last_sensed_ff <= '0;
      end else if (advance) begin
         integ_acc_ff   <= i_in;
         deriv_acc_ff   <= d_in;
         last_error_ff  <= err;
         last_sensed_ff <= s1_sensed_ff;
      end
   end

   // ---------------------------------------------------------------- result register
   logic signed [CW-1:0] drive_ff, p_part_ff, i_part_ff, d_part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff  <= drive_in;
         p_part_ff <= p_in;
         i_part_ff <= i_in;
         d_part_ff <= d_in;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.drive  = drive_ff;
   assign rsp_ch.p_part = p_part_ff;
   assign rsp_ch.i_part = i_part_ff;
   assign rsp_ch.d_part = d_part_ff;

endmodule

### tb/sv/tb_pid_controller_filtered_derivative_core.sv
// Self-checking testbench for the PID controller core with filtered derivative.
module tb_pid_controller_filtered_derivative_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     SW          = pcfd_pkg::SAMPLE_WIDTH_DEF;
   localparam int     FB          = pcfd_pkg::FRAC_BITS_DEF;
   // Products are capped at +-2^61 before any sum or shift.
   localparam longint PROD_CAP    = longint'(1) <<< 61;
   // Long result-side hold-off used to fill the core and stall its input.
   localparam int     HOLD_CYCLES = 300;
   // Stop point of the random part, in items.
   localparam int     RANDOM_ITEMS = 1540;

   typedef logic signed [SW-1:0]               sample_type;
   typedef logic signed [pcfd_pkg::COEF_W-1:0] q_type;

   typedef struct packed {
      q_type drive;
      q_type p_part;
      q_type i_part;
      q_type d_part;
   } pid_result_type;

   logic                            clock;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [pcfd_pkg::CSR_ADDR_W-1:0] paddr;
   logic [pcfd_pkg::CSR_DATA_W-1:0] pwdata;
   logic [pcfd_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   pcfd_req_if #(.SAMPLE_WIDTH(SW)) req_ch ();
   pcfd_rsp_if                      rsp_ch ();

   pid_controller_filtered_derivative_core #(
      .SAMPLE_WIDTH (SW),
      .FRAC_BITS    (FB)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow copy of the coefficient registers, indexed by register code.
   q_type          csr_shadow [8];
   // Controller state as the core should hold it.
   longint         integ_state;
   longint         deriv_state;
   longint         prev_error;
   longint         prev_sensed;
   // Results still owed by the core, oldest first.
   pid_result_type expected_q [$];
   int             mismatch_count = 0;
   // Idling controls: steady means no gaps on that side; hold_off is a
   // one-shot receiver stall counted down by the result sink.
   bit             tx_steady = 1'b0;
   bit             rx_steady = 1'b0;
   int             hold_off = 0;

   // ---------------------------------------------------------------- predictor

   function automatic longint sat_q(input longint x);
      if (x > longint'(pcfd_pkg::Q_MAX)) return longint'(pcfd_pkg::Q_MAX);
      if (x < longint'(pcfd_pkg::Q_MIN)) return longint'(pcfd_pkg::Q_MIN);
      return x;
   endfunction

   // 32x32 always fits in 64 bits, so the cap can be applied after the multiply.
   function automatic longint capped_product(input longint a, input longint b);
      longint p;
      p = a * b;
      if (p > PROD_CAP) p = PROD_CAP;
      else if (p < -PROD_CAP) p = -PROD_CAP;
      return p;
   endfunction

   // Low bound first, then high: crossed limits resolve to the high one.
   function automatic longint clip(input longint x, input longint lo, input longint hi);
      longint r;
      r = x;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   // One control step: returns the result and advances the tracked state.
   function automatic pid_result_type advance_controller(input sample_type tgt,
                                                         input sample_type meas);
      longint         err;
      longint         p;
      longint         i;
      longint         d;
      longint         pole_term;
      longint         y;
      pid_result_type r;
      err = longint'(tgt) - longint'(meas);
      p = sat_q(capped_product(csr_shadow[pcfd_pkg::CSR_PROP_GAIN], err));
      // trapezoidal integrator, gain already holds Ki*T/2
      i = sat_q(integ_state
                + capped_product(csr_shadow[pcfd_pkg::CSR_INTEG_GAIN], err + prev_error));
      if (csr_shadow[pcfd_pkg::CSR_INTEG_LOW] != 0 || csr_shadow[pcfd_pkg::CSR_INTEG_HIGH] != 0)
         i = clip(i, csr_shadow[pcfd_pkg::CSR_INTEG_LOW], csr_shadow[pcfd_pkg::CSR_INTEG_HIGH]);
      // pole * previous d, rounded half up, then floor shift
      pole_term = (capped_product(csr_shadow[pcfd_pkg::CSR_DERIV_POLE], deriv_state)
                   + (longint'(1) <<< (FB - 1))) >>> FB;
      d = sat_q(pole_term
                - capped_product(csr_shadow[pcfd_pkg::CSR_DERIV_GAIN],
                                 longint'(meas) - prev_sensed));
      y = clip(sat_q(p + i + d), csr_shadow[pcfd_pkg::CSR_OUT_LOW],
               csr_shadow[pcfd_pkg::CSR_OUT_HIGH]);
      integ_state = i;
      deriv_state = d;
      prev_error  = err;
      prev_sensed = longint'(meas);
      r.drive  = q_type'(y);
      r.p_part = q_type'(p);
      r.i_part = q_type'(i);
      r.d_part = q_type'(d);
      return r;
   endfunction

   // ------------------------------------------------------------ clock, limit

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("[pid_controller_filtered_derivative_core] ERROR");
      $finish;
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------- result side

   // Receiver: random stalls, plus the long hold-off when one is requested.
   initial begin : result_sink
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off--;
         end else if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            stall = rx_steady ? 0 : idle_cycles();
            rsp_ch.ready <= (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   task automatic compare_field(input string name, input q_type want, input q_type got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Every accepted result is matched against the oldest expectation.
   always @(posedge clock) begin
      pid_result_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing pending, drive %h", $time, rsp_ch.drive);
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            compare_field("drive", want.drive, rsp_ch.drive);
            compare_field("p_part", want.p_part, rsp_ch.p_part);
            compare_field("i_part", want.i_part, rsp_ch.i_part);
            compare_field("d_part", want.d_part, rsp_ch.d_part);
         end
      end
   end

   // -------------------------------------------------------------- input side

   // Offers one item, waits for the handshake, records the prediction.
   // valid stays high when no gap follows, so back-to-back items never
   // lower and raise it in the same step.
   task automatic send_sample(input sample_type tgt, input sample_type meas);
      int gap;
      req_ch.valid  <= 1'b1;
      req_ch.target <= tgt;
      req_ch.sensed <= meas;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_q.push_back(advance_controller(tgt, meas));
      gap = tx_steady ? 0 : idle_cycles();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Must follow the last send_sample of a burst in the same step.
   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Idle point: everything owed has arrived.
   task automatic await_outputs();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ----------------------------------------------------------- register port

   task automatic read_check_coef(input pcfd_pkg::csr_index_type idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== csr_shadow[idx]) begin
         $display("%0t: register %s readback mismatch, expected %h, actual %h",
                  $time, idx.name(), csr_shadow[idx], prdata);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write, then read back.
   task automatic set_coef(input pcfd_pkg::csr_index_type idx, input q_type val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      csr_shadow[idx] = val;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      read_check_coef(idx);
   endtask

   task automatic load_coefs(input q_type kp, input q_type ki, input q_type kd,
                             input q_type pole, input q_type out_lo, input q_type out_hi,
                             input q_type int_lo, input q_type int_hi);
      set_coef(pcfd_pkg::CSR_PROP_GAIN, kp);
      set_coef(pcfd_pkg::CSR_INTEG_GAIN, ki);
      set_coef(pcfd_pkg::CSR_DERIV_GAIN, kd);
      set_coef(pcfd_pkg::CSR_DERIV_POLE, pole);
      set_coef(pcfd_pkg::CSR_OUT_LOW, out_lo);
      set_coef(pcfd_pkg::CSR_OUT_HIGH, out_hi);
      set_coef(pcfd_pkg::CSR_INTEG_LOW, int_lo);
      set_coef(pcfd_pkg::CSR_INTEG_HIGH, int_hi);
   endtask

   // Gains: mostly within +-4.0, sometimes extreme or arbitrary.
   function automatic q_type any_gain();
      case ($urandom_range(0, 9))
         0:       return pcfd_pkg::Q_MAX;
         1:       return pcfd_pkg::Q_MIN;
         2:       return '0;
         3:       return q_type'($urandom);
         default: return q_type'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
      endcase
   endfunction

   // Pole: mostly within +-1.0, sometimes extreme or arbitrary.
   function automatic q_type any_pole();
      case ($urandom_range(0, 9))
         0:       return pcfd_pkg::Q_MAX;
         1:       return pcfd_pkg::Q_MIN;
         2:       return '0;
         3:       return q_type'($urandom);
         default: return q_type'(int'($urandom_range(0, 32'h20000)) - 32'h10000);
      endcase
   endfunction

   // Limit pair: open, ordered, crossed or one-sided. For the integrator,
   // "open" is both zero, and one-sided keeps a zero bound.
   task automatic pick_limits(input bit for_integ, output q_type lo, output q_type hi);
      q_type a;
      q_type b;
      a = q_type'($urandom);
      b = q_type'($urandom);
      if ($urandom_range(0, 1)) begin
         // narrow window around zero, so clamping actually bites
         a = a >>> 12;
         b = b >>> 12;
      end
      case ($urandom_range(0, 5))
         0: begin
            lo = for_integ ? q_type'(0) : pcfd_pkg::Q_MIN;
            hi = for_integ ? q_type'(0) : pcfd_pkg::Q_MAX;
         end
         1: begin
            lo = (a < b) ? b : a;
            hi = (a < b) ? a : b;
         end
         2: begin
            lo = for_integ ? q_type'(0) : ((a < b) ? a : b);
            hi = for_integ ? ((a < b) ? b : a) : pcfd_pkg::Q_MAX;
         end
         3: begin
            lo = for_integ ? ((a < b) ? a : b) : pcfd_pkg::Q_MIN;
            hi = for_integ ? q_type'(0) : ((a < b) ? b : a);
         end
         default: begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
         end
      endcase
   endtask

   // ------------------------------------------------------------------ tests

   // Register defaults read back; zero gains give all-zero results.
   task automatic test_reset_defaults();
      for (int k = 0; k < 8; k++) read_check_coef(pcfd_pkg::csr_index_type'(k));
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sh1234, -16'sd5);
      stop_sending();
      await_outputs();
   endtask

   // Sample extremes with moderate gains; both integrator bounds zero, so
   // the integrator runs unclamped.
   task automatic test_sample_extremes();
      load_coefs(32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000, 32'sh0000_8000,
                 pcfd_pkg::Q_MIN, pcfd_pkg::Q_MAX, '0, '0);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sh0000, 16'sh0000);
      send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'shFFFF, 16'sh0000);
      send_sample(16'sh0000, 16'shFFFF);
      send_sample(16'sh5555, 16'shAAAA);
      stop_sending();
      await_outputs();
   endtask

   // Extreme coefficients: the terms and the sum all saturate, and the
   // pole product reaches its cap.
   task automatic test_saturation();
      load_coefs(pcfd_pkg::Q_MAX, pcfd_pkg::Q_MAX, pcfd_pkg::Q_MIN, pcfd_pkg::Q_MIN,
                 pcfd_pkg::Q_MIN, pcfd_pkg::Q_MAX, '0, '0);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh0000, 16'sh0000);
      stop_sending();
      await_outputs();
   endtask

   // Low bound above high bound, on output and integrator: high bound wins.
   task automatic test_crossed_limits();
      load_coefs(32'sh0001_0000, 32'sh0000_8000, 32'sh0000_4000, 32'sh0000_8000,
                 32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000, -32'sh0002_0000);
      send_sample(16'sd100, -16'sd100);
      send_sample(-16'sd200, 16'sd50);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh0000, 16'sh0000);
      stop_sending();
      await_outputs();
   endtask

   // One integrator bound zero, the other not: clamping is active and the
   // integrator pins at both ends.
   task automatic test_integ_clamp();
      load_coefs(32'sh0000_4000, 32'sh0001_0000, '0, '0,
                 -32'sh0005_0000, 32'sh0005_0000, '0, 32'sh0003_0000);
      send_sample(16'sd3, 16'sd0);
      send_sample(16'sd2, 16'sd0);
      send_sample(16'sd0, 16'sd5);
      send_sample(-16'sd4, 16'sd3);
      stop_sending();
      await_outputs();
   endtask

   // Receiver holds off for a long stretch while items keep coming, then the
   // sender waits for every result before the next burst.
   task automatic test_backpressure();
      load_coefs(32'sh0001_0000, 32'sh0000_4000, 32'sh0000_8000, 32'sh0000_C000,
                 pcfd_pkg::Q_MIN, pcfd_pkg::Q_MAX, '0, '0);
      tx_steady = 1'b1;
      hold_off  = HOLD_CYCLES;
      repeat (60) send_sample(sample_type'($urandom), sample_type'($urandom));
      stop_sending();
      await_outputs();
      tx_steady = 1'b0;
      repeat (60) send_sample(sample_type'($urandom), sample_type'($urandom));
      stop_sending();
      await_outputs();
   endtask

   // Random coefficient sets, each followed by a burst of items in one of
   // three styles: full-range noise, small values, or a held setpoint with a
   // slowly wandering measurement.
   task automatic test_random_operation();
      int         total;
      int         phase_items;
      int         style;
      int         setpoint;
      int         walk;
      q_type      olo;
      q_type      ohi;
      q_type      ilo;
      q_type      ihi;
      sample_type tgt;
      sample_type meas;
      total    = 0;
      setpoint = 0;
      walk     = 0;
      while (total < RANDOM_ITEMS) begin
         pick_limits(1'b0, olo, ohi);
         pick_limits(1'b1, ilo, ihi);
         load_coefs(any_gain(), any_gain(), any_gain(), any_pole(), olo, ohi, ilo, ihi);
         style       = $urandom_range(0, 3);
         tx_steady   = ($urandom_range(0, 4) == 0);
         rx_steady   = ($urandom_range(0, 4) == 0);
         phase_items = $urandom_range(40, 200);
         repeat (phase_items) begin
            case (style)
               0: begin
                  tgt  = sample_type'($urandom);
                  meas = sample_type'($urandom);
               end
               1: begin
                  tgt  = sample_type'(int'($urandom_range(0, 511)) - 256);
                  meas = sample_type'(int'($urandom_range(0, 511)) - 256);
               end
               default: begin
                  if ($urandom_range(0, 19) == 0)
                     setpoint = int'($urandom_range(0, 65535)) - 32768;
                  walk = walk + int'($urandom_range(0, 400)) - 200;
                  if (walk > 32767) walk = 32767;
                  if (walk < -32768) walk = -32768;
                  tgt  = sample_type'(setpoint);
                  meas = sample_type'(walk);
               end
            endcase
            // occasional rail value on either input
            if ($urandom_range(0, 49) == 0) tgt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            if ($urandom_range(0, 49) == 0) meas = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            send_sample(tgt, meas);
         end
         total = total + phase_items;
         stop_sending();
         await_outputs();
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // ------------------------------------------------------------------- main

   initial begin
      reset         <= 1'b1;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.target <= '0;
      req_ch.sensed <= '0;
      for (int k = 0; k < 8; k++) csr_shadow[k] = '0;
      csr_shadow[pcfd_pkg::CSR_OUT_LOW]  = pcfd_pkg::Q_MIN;
      csr_shadow[pcfd_pkg::CSR_OUT_HIGH] = pcfd_pkg::Q_MAX;
      integ_state = 0;
      deriv_state = 0;
      prev_error  = 0;
      prev_sensed = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_sample_extremes();
      test_saturation();
      test_crossed_limits();
      test_integ_clamp();
      test_backpressure();
      test_random_operation();

      await_outputs();
      if (mismatch_count == 0) begin
         $display("[pid_controller_filtered_derivative_core] OK");
      end else begin
         $display("[pid_controller_filtered_derivative_core] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
src/pcfd_pkg.sv
src/pcfd_req_if.sv
src/pid_controller_filtered_derivative_core.sv
tb/sv/tb_pid_controller_filtered_derivative_core.sv
